// ----- design/cswq_pkg.sv -----
// ----------------------------------------------------------------------------
// cswq_pkg: shared types and codes for the semaphore wait queue
// Request opcodes, response status codes and the queue cell control bundle.
// ----------------------------------------------------------------------------
package cswq_pkg;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int TID_W    = 8;
   localparam int VALUE_W  = 17;
   localparam int INIT_W   = 16;

   typedef enum logic [OP_W-1:0] {
      OP_DOWN   = 2'd0,
      OP_UP     = 2'd1,
      OP_READ   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_BLOCKED   = 3'd1,
      ST_WOKEN     = 3'd2,
      ST_INCREMENT = 3'd3,
      ST_FULL      = 3'd4,
      ST_SATURATED = 3'd5,
      ST_VALUE     = 3'd6
   } status_type;

   // per-cell control: shift takes the neighbor's id, load takes the pushed id
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ----- design/cswq_cell.sv -----
// ----------------------------------------------------------------------------
// cswq_cell: one slot of the wait queue
// Holds one waiting thread id; on a pop it takes its upstream neighbor's id,
// on a push addressed to it it takes the incoming id.
// ----------------------------------------------------------------------------
module cswq_cell
   import cswq_pkg::*;
#(
   parameter int ID_BITS = 8
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [ID_BITS-1:0] neighbor_id,
   input  logic [ID_BITS-1:0] push_id,
   output logic [ID_BITS-1:0] id
);

   logic [ID_BITS-1:0] id_ff;
   logic [ID_BITS-1:0] id_in;

   always_comb begin
      id_in = id_ff;
      if (ctl.shift) begin
         id_in = neighbor_id;
      end else if (ctl.load) begin
         id_in = push_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;

endmodule

// ----- design/counting_semaphore_wait_queue_top.sv -----
// ----------------------------------------------------------------------------
// Response: each response beat is registered from its accepted request beat.
// Throughput: one request per cycle unless a response is stalled; the count
//   update and the cell shift or load finish in the cycle of acceptance.
// Reset: synchronous; clears the count, queue occupancy and response valid.
//   Queue cell contents are not reset.
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_top: counting semaphore with FIFO wait queue
// Down takes a unit or queues the requester; up wakes the oldest waiter or
// adds a unit; READ/UNUSED report the count or minus the number of waiters.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top
   import cswq_pkg::*;
#(
   parameter int QUEUE_DEPTH    = 16,
   parameter int THREAD_ID_BITS = 8,
   parameter int COUNT_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_op,
   input  logic [TID_W-1:0]          req_thread_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [TID_W-1:0]          rsp_woken_thread,
   output logic signed [VALUE_W-1:0] rsp_sem_value,
   input  logic                      csr_we,
   input  logic [INIT_W-1:0]         csr_wdata
);

   localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [TOT_W-1:0]          total_ff, total_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [TID_W-1:0]          woken_ff, woken_in;
   logic [VALUE_W-1:0]        value_ff, value_in;

   logic                      accept;
   logic                      push, pop;
   logic [THREAD_ID_BITS-1:0] push_id;
   logic [THREAD_ID_BITS-1:0] cell_id [QUEUE_DEPTH];
   cell_ctl_type              cell_ctl [QUEUE_DEPTH];

   logic [THREAD_ID_BITS+TID_W-1:0]  tid_ext;
   logic [THREAD_ID_BITS+TID_W-1:0]  head_ext;
   logic [COUNT_BITS+INIT_W-1:0]     init_ext;
   logic [COUNT_BITS+VALUE_W-1:0]    count_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign tid_ext   = {{THREAD_ID_BITS{1'b0}}, req_thread_id};
   assign push_id   = tid_ext[THREAD_ID_BITS-1:0];
   assign head_ext  = {{TID_W{1'b0}}, cell_id[0]};
   assign init_ext  = {{COUNT_BITS{1'b0}}, csr_wdata};
   assign count_ext = {{VALUE_W{1'b0}}, count_ff};

   always_comb begin
      count_in  = count_ff;
      total_in  = total_ff;
      push      = 1'b0;
      pop       = 1'b0;
      status_in = ST_VALUE;
      woken_in  = '0;
      value_in  = '0;
      case (op_type'(req_op))
         OP_DOWN: begin
            if (count_ff != '0) begin
               count_in  = count_ff - 1'b1;
               status_in = ST_GRANTED;
            end else if (total_ff == TOT_W'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               push      = 1'b1;
               total_in  = total_ff + 1'b1;
               status_in = ST_BLOCKED;
            end
         end
         OP_UP: begin
            if (total_ff != '0) begin
               pop       = 1'b1;
               total_in  = total_ff - 1'b1;
               woken_in  = head_ext[TID_W-1:0];
               status_in = ST_WOKEN;
            end else if (&count_ff) begin
               status_in = ST_SATURATED;
            end else begin
               count_in  = count_ff + 1'b1;
               status_in = ST_INCREMENT;
            end
         end
         default: begin
            status_in = ST_VALUE;
            if (count_ff != '0) begin
               value_in = count_ext[VALUE_W-1:0];
            end else begin
               value_in = VALUE_W'(0) - VALUE_W'(total_ff);
            end
         end
      endcase
      if (!accept) begin
         push     = 1'b0;
         pop      = 1'b0;
         count_in = count_ff;
         total_in = total_ff;
      end
      if (csr_we) begin
         push     = 1'b0;
         pop      = 1'b0;
         count_in = init_ext[COUNT_BITS-1:0];
         total_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic [THREAD_ID_BITS-1:0] neighbor;
         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign neighbor = push_id;
         end else begin : g_mid
            assign neighbor = cell_id[i+1];
         end
         assign cell_ctl[i].shift = pop;
         assign cell_ctl[i].load  = push && (total_ff == TOT_W'(i));
         cswq_cell #(
            .ID_BITS (THREAD_ID_BITS)
         ) u_cell (
            .clock       (clock),
            .ctl         (cell_ctl[i]),
            .neighbor_id (neighbor),
            .push_id     (push_id),
            .id          (cell_id[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         woken_ff  <= woken_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_woken_thread = woken_ff;
   assign rsp_sem_value    = value_ff;

endmodule

// ----- test/tb_counting_semaphore_wait_queue_top.sv -----
// ----------------------------------------------------------------------------
// tb_counting_semaphore_wait_queue_top
// Drives down/up/read/unused beats into the semaphore, predicts each response
// with a local count and wait-queue copy, and checks every response beat in
// order. Covers saturation, queue full, count reloads over waiters, a long
// response stall and random traffic under three idle mixes.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_wait_queue_top;
   import cswq_pkg::*;

   localparam int          WAIT_DEPTH     = 16;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam int          RX_HOLD_CYCLES = 150;
   localparam int          STALL_LIMIT    = 2000;

   typedef struct packed {
      status_type                 status;
      logic [TID_W-1:0]           woken;
      logic signed [VALUE_W-1:0]  value;
   } sem_response_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OP_W-1:0]           req_op;
   logic [TID_W-1:0]          req_thread_id;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STATUS_W-1:0]       rsp_status;
   logic [TID_W-1:0]          rsp_woken_thread;
   logic signed [VALUE_W-1:0] rsp_sem_value;
   logic                      csr_we;
   logic [INIT_W-1:0]         csr_wdata;

   logic [15:0]       sem_count;
   logic [TID_W-1:0]  sem_waiters[$];
   sem_response_type  pending_responses[$];
   sem_response_type  oldest_resp;

   int error_count  = 0;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int rx_hold_id   = 0;
   int hold_id_seen = 0;
   int hold_left    = 0;
   int stall_cycles = 0;

   counting_semaphore_wait_queue_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_thread_id    (req_thread_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_woken_thread (rsp_woken_thread),
      .rsp_sem_value    (rsp_sem_value),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   function automatic sem_response_type compute_sem_response(input op_type op,
                                                             input logic [TID_W-1:0] tid);
      sem_response_type r;
      logic [VALUE_W-1:0] v;
      r = '0;
      case (op)
         OP_DOWN: begin
            if (sem_count != 0) begin
               sem_count--;
               r.status = ST_GRANTED;
            end else if (sem_waiters.size() >= WAIT_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               sem_waiters.push_back(tid);
               r.status = ST_BLOCKED;
            end
         end
         OP_UP: begin
            if (sem_waiters.size() != 0) begin
               r.woken  = sem_waiters.pop_front();
               r.status = ST_WOKEN;
            end else if (sem_count == COUNT_MAX) begin
               r.status = ST_SATURATED;
            end else begin
               sem_count++;
               r.status = ST_INCREMENT;
            end
         end
         default: begin
            if (sem_count != 0) v = {1'b0, sem_count};
            else v = '0 - VALUE_W'(sem_waiters.size());
            r.value  = v;
            r.status = ST_VALUE;
         end
      endcase
      return r;
   endfunction

   task automatic send_beat(input op_type op, input logic [TID_W-1:0] tid);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_thread_id <= tid;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(compute_sem_response(op, tid));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic load_count(input logic [INIT_W-1:0] value);
      wait_drain();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sem_count = value;
      sem_waiters.delete();
   endtask

   task automatic send_random_beat();
      int r;
      op_type op;
      r = $urandom_range(99);
      if (r < 42) op = OP_DOWN;
      else if (r < 84) op = OP_UP;
      else if (r < 96) op = OP_READ;
      else op = OP_UNUSED;
      send_beat(op, TID_W'($urandom_range(255)));
   endtask

   task automatic test_saturation();
      load_count(16'hFFFE);
      send_beat(OP_UP, 8'h00);
      send_beat(OP_UP, 8'hFF);
      send_beat(OP_READ, 8'hA5);
      send_beat(OP_UNUSED, 8'h5A);
   endtask

   task automatic test_queue_full();
      load_count(16'h0000);
      send_beat(OP_READ, 8'h00);
      send_beat(OP_DOWN, 8'hFF);
      send_beat(OP_DOWN, 8'h00);
      for (int i = 0; i < WAIT_DEPTH - 2; i++) begin
         send_beat(OP_DOWN, TID_W'($urandom_range(255)));
      end
      send_beat(OP_DOWN, 8'h3C);
      send_beat(OP_READ, 8'h00);
      send_beat(OP_UP, 8'h00);
   endtask

   task automatic test_reload_over_waiters();
      load_count(16'h0002);
      send_beat(OP_READ, 8'hFF);
      send_beat(OP_DOWN, 8'h11);
   endtask

   task automatic test_backpressure();
      load_count(16'h0000);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_id++;
      for (int i = 0; i < 30; i++) send_random_beat();
      // sender holds off until every response is back
      wait_drain();
   endtask

   task automatic test_random(input int n, input int tx_pct, input int rx_pct,
                              input logic [INIT_W-1:0] init);
      load_count(init);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < n; i++) send_random_beat();
   endtask

   // response receiver
   always @(posedge clock) begin
      if (hold_id_seen != rx_hold_id) begin
         hold_id_seen <= rx_hold_id;
         hold_left    <= RX_HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            oldest_resp = pending_responses.pop_front();
            if (rsp_status !== oldest_resp.status)
               report_mismatch($sformatf("status got %0d exp %0d",
                                         rsp_status, oldest_resp.status));
            if (rsp_woken_thread !== oldest_resp.woken)
               report_mismatch($sformatf("woken_thread got %0d exp %0d",
                                         rsp_woken_thread, oldest_resp.woken));
            if (rsp_sem_value !== oldest_resp.value)
               report_mismatch($sformatf("sem_value got %0d exp %0d",
                                         rsp_sem_value, oldest_resp.value));
         end
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_op        <= OP_DOWN;
      req_thread_id <= '0;
      rsp_ready     <= 1'b0;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      sem_count     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_saturation();
      test_queue_full();
      test_reload_over_waiters();
      test_backpressure();
      test_random(110, 31, 58, 16'h0000);
      test_random(110, 31, 58, 16'h0005);
      test_random(100, 58, 31, 16'hFFFF);
      test_random(110, 58, 31, INIT_W'($urandom_range(20)));
      test_random(110, 0, 0, 16'h0001);
      test_random(80, 0, 0, INIT_W'($urandom_range(65535)));

      wait_drain();
      repeat (5) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   pending_responses.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- counting_semaphore_wait_queue_top.f -----
design/cswq_pkg.sv
design/cswq_cell.sv
design/counting_semaphore_wait_queue_top.sv
test/tb_counting_semaphore_wait_queue_top.sv
